>>> rtl/bpi_pkg.sv
// Shared types, constants and channel unpacking for the bilinear pixel interpolator.
// No dependencies; every other file in rtl/ imports this package.
package bpi_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int WEIGHT_W      = FRACTION_BITS + 1;
  localparam int NUM_LANES     = 4;
  localparam int CHAN_W        = 16;
  localparam int PIX_W         = 64;

  localparam logic [1:0] FMT_BGR8   = 2'd0;
  localparam logic [1:0] FMT_RGBA8  = 2'd1;
  localparam logic [1:0] FMT_RGBA16 = 2'd2;

  localparam logic [1:0] LANE_RED   = 2'd0;
  localparam logic [1:0] LANE_GREEN = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;
  localparam logic [1:0] LANE_ALPHA = 2'd3;

  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_top_left;
    logic [PIX_W-1:0]    pixel_top_right;
    logic [PIX_W-1:0]    pixel_bottom_left;
    logic [PIX_W-1:0]    pixel_bottom_right;
    logic [WEIGHT_W-1:0] frac_x;
    logic [WEIGHT_W-1:0] frac_y;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } out_item_t;

  // One load enable per pipeline register rank; the last rank is the output register.
  typedef struct packed {
    logic [NUM_LANES:0] en;
  } stage_adv_t;

  typedef logic [NUM_LANES-1:0][CHAN_W-1:0] lane_chans_t;

  // Clamp an offset above one to exactly one.
  function automatic logic [WEIGHT_W-1:0] sat_frac(logic [WEIGHT_W-1:0] f);
    logic [WEIGHT_W-1:0] one;
    one = {1'b1, {FRACTION_BITS{1'b0}}};
    return (f > one) ? one : f;
  endfunction

  // Pull one channel out of a packed pixel, widened to 16 bits (x257 for 8-bit).
  function automatic logic [CHAN_W-1:0] chan_sel(logic [PIX_W-1:0] pix, logic [1:0] fmt,
                                                 logic [1:0] lane);
    logic [7:0] b;
    b = 8'd0;
    case (fmt)
      FMT_BGR8: begin
        case (lane)
          LANE_RED:   b = pix[23:16];
          LANE_GREEN: b = pix[15:8];
          default:    b = pix[7:0];
        endcase
        return {b, b};
      end
      FMT_RGBA8: begin
        b = pix[8*lane +: 8];
        return {b, b};
      end
      default: return pix[16*lane +: 16];
    endcase
  endfunction

endpackage

>>> rtl/bpi_lane.sv
// One color channel of the bilinear blend: x weights, row sums, y partial products, round.
// Depends on bpi_pkg; stage enables come from the top level's pipeline control.
module bpi_lane
  import bpi_pkg::*;
(
  input  logic                               clk,
  input  stage_adv_t                         adv,
  input  logic [NUM_LANES-1:0][CHAN_W-1:0]   chans,
  input  logic [WEIGHT_W-1:0]                fx,
  input  logic [WEIGHT_W-1:0]                fy,
  output logic [CHAN_W-1:0]                  res
);

  localparam int PW = CHAN_W + FRACTION_BITS;      // one weighted corner, also a row sum
  localparam int HW = FRACTION_BITS;               // upper slice of a row sum
  localparam int HPW = HW + WEIGHT_W;
  localparam int LPW = CHAN_W + WEIGHT_W;
  localparam int SW = CHAN_W + 2 * FRACTION_BITS;  // full blend before rounding
  localparam logic [WEIGHT_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF = SW'(1) << (2 * FRACTION_BITS - 1);

  logic [WEIGHT_W-1:0] gx, gy;
  logic [PW-1:0] m00_r, m10_r, m01_r, m11_r;
  logic [WEIGHT_W-1:0] fy1_r, gy1_r, fy2_r, gy2_r;
  logic [PW-1:0] top_r, bot_r;
  logic [HPW-1:0] pth_r, pbh_r;
  logic [LPW-1:0] ptl_r, pbl_r;
  logic [SW-1:0] sum_c;
  logic [CHAN_W-1:0] res_r;

  assign gx = ONE - fx;
  assign gy = ONE - fy;

  // weight each corner along x
  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      m00_r <= PW'(chans[0]) * PW'(gx);
      m10_r <= PW'(chans[1]) * PW'(fx);
      m01_r <= PW'(chans[2]) * PW'(gx);
      m11_r <= PW'(chans[3]) * PW'(fx);
      fy1_r <= fy;
      gy1_r <= gy;
    end
  end

  // row sums never exceed 65535 * ONE, so PW bits hold them
  always_ff @(posedge clk) begin
    if (adv.en[1]) begin
      top_r <= m00_r + m10_r;
      bot_r <= m01_r + m11_r;
      fy2_r <= fy1_r;
      gy2_r <= gy1_r;
    end
  end

  // split each row sum so the y multiply stays narrow
  always_ff @(posedge clk) begin
    if (adv.en[2]) begin
      pth_r <= HPW'(top_r[PW-1:CHAN_W]) * HPW'(gy2_r);
      pbh_r <= HPW'(bot_r[PW-1:CHAN_W]) * HPW'(fy2_r);
      ptl_r <= LPW'(top_r[CHAN_W-1:0]) * LPW'(gy2_r);
      pbl_r <= LPW'(bot_r[CHAN_W-1:0]) * LPW'(fy2_r);
    end
  end

  // the rounded blend never exceeds 65535, so no clamp is needed
  assign sum_c = SW'((SW'(pth_r) + SW'(pbh_r)) << CHAN_W) + SW'(ptl_r) + SW'(pbl_r) + HALF;

  always_ff @(posedge clk) begin
    if (adv.en[3]) begin
      res_r <= sum_c[SW-1:2*FRACTION_BITS];
    end
  end

  assign res = res_r;

endmodule

>>> rtl/bpi_merge.sv
// Output register: gathers the four lane results and forces alpha for the BGR format.
// Depends on bpi_pkg.
module bpi_merge
  import bpi_pkg::*;
(
  input  logic        clk,
  input  stage_adv_t  adv,
  input  logic [1:0]  fmt,
  input  lane_chans_t lane_res,
  output out_item_t   item
);

  out_item_t item_r;

  always_ff @(posedge clk) begin
    if (adv.en[NUM_LANES]) begin
      item_r.red_out   <= lane_res[LANE_RED];
      item_r.green_out <= lane_res[LANE_GREEN];
      item_r.blue_out  <= lane_res[LANE_BLUE];
      item_r.alpha_out <= (fmt == FMT_BGR8) ? {CHAN_W{1'b1}} : lane_res[LANE_ALPHA];
    end
  end

  assign item = item_r;

endmodule

>>> rtl/bilinear_pixel_interpolator_unit.sv
// Top level of the bilinear pixel interpolator: config register, pipeline control, lanes.
// Depends on bpi_pkg, bpi_lane and bpi_merge.
//
// Takes one item per clock while in_stall is low: four packed neighbor pixels and Q1.16
// offsets (values above 1.0 clamp to 1.0), and returns one result item per input with four
// 16-bit channels, 65535 meaning full intensity. Four channel lanes run side by side, each
// a four-rank pipeline (x weighting, row sums, split y products, rounding); a merge rank
// forms the output register and forces alpha to full for BGR. Sustained rate is one item
// per clock while out_stall is low. Each rank advances when it is empty or the rank after
// it moves, so bubbles close up and inputs keep being taken while a result waits on
// out_stall, until every rank is full. pixel_format lives at byte address 0 of the config
// port (reset: RGBA 8-bit) and must only be written while the pipeline is empty.
module bilinear_pixel_interpolator_unit
  import bpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] fmt_r;
  logic [NUM_LANES:0] vld_r, vld_nxt;
  logic [NUM_LANES:0] rdy;
  stage_adv_t adv;
  logic [WEIGHT_W-1:0] fx, fy;
  lane_chans_t lane_res;
  logic cfg_sel0;

  // Config port: one register, decoded on the word index only.
  assign pready   = 1'b1;
  assign cfg_sel0 = (paddr[2] == REG_PIXEL_FORMAT[0]);
  assign prdata   = cfg_sel0 ? {30'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGBA8;
    end else if (psel && penable && pwrite && pready && cfg_sel0) begin
      fmt_r <= pwdata[1:0];
    end
  end

  // Ready ripples back from the output: a rank loads if empty or if its successor moves.
  always_comb begin
    rdy[NUM_LANES] = !vld_r[NUM_LANES] || !out_stall;
    for (int k = NUM_LANES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign adv.en   = rdy;
  assign in_stall = !rdy[0];

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k <= NUM_LANES; k++) begin
      if (rdy[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[NUM_LANES];

  // Clamp offsets once, shared by all lanes.
  assign fx = sat_frac(in_item.frac_x);
  assign fy = sat_frac(in_item.frac_y);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [NUM_LANES-1:0][CHAN_W-1:0] chans;

    // Unpack this lane's channel from each corner; order is TL, TR, BL, BR.
    assign chans[0] = chan_sel(in_item.pixel_top_left, fmt_r, 2'(g));
    assign chans[1] = chan_sel(in_item.pixel_top_right, fmt_r, 2'(g));
    assign chans[2] = chan_sel(in_item.pixel_bottom_left, fmt_r, 2'(g));
    assign chans[3] = chan_sel(in_item.pixel_bottom_right, fmt_r, 2'(g));

    bpi_lane u_lane (
      .clk   (clk),
      .adv   (adv),
      .chans (chans),
      .fx    (fx),
      .fy    (fy),
      .res   (lane_res[g])
    );
  end

  bpi_merge u_merge (
    .clk      (clk),
    .adv      (adv),
    .fmt      (fmt_r),
    .lane_res (lane_res),
    .item     (out_item)
  );

endmodule

>>> bench/bilinear_pixel_interpolator_unit_tb.sv
// Self-checking bench for bilinear_pixel_interpolator_unit: directed corner cases, then
// random phases in every pixel format. Depends on bpi_pkg and the RTL top level only.
module bilinear_pixel_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpi_pkg::*;

  // Format code three is not named in the package; the block treats it as 16-bit RGBA.
  localparam logic [1:0] FMT_ALIAS16 = 2'd3;
  // Register index one has no register behind it; writes there must be ignored.
  localparam int REG_UNUSED     = 1;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES     = 7;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 400000;
  localparam longint unsigned UNITY = 64'd1 << FRACTION_BITS;

  // Expected-pixel store and blend predictor. Tracks its own copy of pixel_format.
  class blend_checker;
    logic [1:0] fmt;
    out_item_t  expected_pixels[$];
    int         errors;

    function new();
      fmt = FMT_RGBA8;
      errors = 0;
    endfunction

    // Channel of one packed pixel, widened to 16 bits.
    function logic [15:0] widen(logic [63:0] pix, int lane);
      int         sh;
      logic       wide;
      logic [7:0] b;
      case (fmt)
        FMT_BGR8: begin
          sh = (lane == 0) ? 16 : (lane == 1) ? 8 : 0;
          wide = 1'b0;
        end
        FMT_RGBA8: begin
          sh = 8 * lane;
          wide = 1'b0;
        end
        default: begin
          sh = 16 * lane;
          wide = 1'b1;
        end
      endcase
      if (wide) return 16'(pix >> sh);
      b = 8'(pix >> sh);
      return {b, b};
    endfunction

    // Exact bilinear sum, one round to nearest with halves up.
    function logic [15:0] mix(logic [15:0] c00, logic [15:0] c10, logic [15:0] c01,
                              logic [15:0] c11, longint unsigned fx, longint unsigned fy);
      longint unsigned gx, gy, top, bot, s, r;
      gx  = UNITY - fx;
      gy  = UNITY - fy;
      top = 64'(c00) * gx + 64'(c10) * fx;
      bot = 64'(c01) * gx + 64'(c11) * fx;
      s   = top * gy + bot * fy;
      r   = (s + (64'd1 << (2 * FRACTION_BITS - 1))) >> (2 * FRACTION_BITS);
      if (r > 64'hFFFF) r = 64'hFFFF;
      return r[15:0];
    endfunction

    function out_item_t blend_pixel(in_item_t it);
      longint unsigned fx, fy;
      logic [15:0]     ch[4];
      out_item_t       res;
      // Offsets above one clamp to exactly one.
      fx = (64'(it.frac_x) > UNITY) ? UNITY : 64'(it.frac_x);
      fy = (64'(it.frac_y) > UNITY) ? UNITY : 64'(it.frac_y);
      for (int lane = 0; lane < 4; lane++) begin
        ch[lane] = mix(widen(it.pixel_top_left, lane), widen(it.pixel_top_right, lane),
                       widen(it.pixel_bottom_left, lane), widen(it.pixel_bottom_right, lane),
                       fx, fy);
      end
      res.red_out   = ch[LANE_RED];
      res.green_out = ch[LANE_GREEN];
      res.blue_out  = ch[LANE_BLUE];
      res.alpha_out = (fmt == FMT_BGR8) ? 16'hFFFF : ch[LANE_ALPHA];
      return res;
    endfunction

    function void note_sample(in_item_t it);
      expected_pixels.push_back(blend_pixel(it));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result %h, expected none", $time, got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("alpha_out", want.alpha_out, got.alpha_out);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  blend_checker sb = new();
  bit           quiet;     // no gaps on either side while set
  bit           hold_req;  // ask the receiver for one long hold-off
  int           cycle_count;
  logic [1:0]   phase_fmt[NUM_PHASES] = '{FMT_BGR8, FMT_RGBA8, FMT_RGBA16, FMT_ALIAS16,
                                          FMT_RGBA8, FMT_BGR8, FMT_RGBA16};

  bilinear_pixel_interpolator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshakes lock up.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bilinear_pixel_interpolator_unit verification failed");
      $finish;
    end
  end

  // Sample both channels at the rising edge: check results first, then note new items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_pixel(out_item);
      if (in_valid && !in_stall) sb.note_sample(in_item);
    end
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: alternate free and stalled stretches; honor a long hold-off on request.
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end
      n = $urandom_range(1, 16);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      n = next_gap();
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_item(logic [63:0] tl, logic [63:0] tr, logic [63:0] bl,
                                         logic [63:0] br, logic [16:0] fx, logic [16:0] fy);
    in_item_t it;
    it.pixel_top_left     = tl;
    it.pixel_top_right    = tr;
    it.pixel_bottom_left  = bl;
    it.pixel_bottom_right = br;
    it.frac_x             = fx;
    it.frac_y             = fy;
    return it;
  endfunction

  function automatic logic [63:0] rand_pixel();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [16:0] rand_frac();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'(UNITY);
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'd32768;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    logic [63:0] p;
    p = rand_pixel();
    case ($urandom_range(0, 9))
      // flat neighborhood: result must equal the pixel itself
      0: return make_item(p, p, p, p, rand_frac(), rand_frac());
      // saturated corners only
      1: return make_item({64{$urandom_range(0, 1) == 1}}, {64{$urandom_range(0, 1) == 1}},
                          {64{$urandom_range(0, 1) == 1}}, {64{$urandom_range(0, 1) == 1}},
                          rand_frac(), rand_frac());
      default: return make_item(p, rand_pixel(), rand_pixel(), rand_pixel(),
                                rand_frac(), rand_frac());
    endcase
  endfunction

  // Offer one item after a random gap; hold it until accepted.
  task automatic send_item(in_item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(int idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PIXEL_FORMAT) sb.fmt = data[1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read pixel_format back and compare with the tracked value.
  task automatic check_format_reg();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * REG_PIXEL_FORMAT);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'd0, sb.fmt}) begin
      $display("%0t: pixel_format read mismatch, expected %h, actual %h",
               $time, {30'd0, sb.fmt}, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, drain every expected result, then let the pipeline empty out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write pixel_format with junk in the upper bits, which must be dropped.
  task automatic set_format(logic [1:0] f);
    write_reg(REG_PIXEL_FORMAT, {30'($urandom_range(0, 32'h3FFF_FFFF)), f});
    check_format_reg();
  endtask

  initial begin
    logic [63:0] pa, pb, pc, pd;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_format_reg();

    // Directed part. Distinct corners so a wrong corner pick shows up.
    pa = 64'h0123_4567_89AB_CDEF;
    pb = 64'hFEDC_BA98_7654_3210;
    pc = 64'h00FF_FF00_F00F_0FF0;
    pd = 64'hA5A5_5A5A_C3C3_3C3C;
    // RGBA 8-bit from reset: each corner exactly, clamped offsets, a rounding half.
    send_item(make_item(pa, pb, pc, pd, 17'd0, 17'd0));
    send_item(make_item(pa, pb, pc, pd, 17'(UNITY), 17'd0));
    send_item(make_item(pa, pb, pc, pd, 17'd0, 17'(UNITY)));
    send_item(make_item(pa, pb, pc, pd, 17'(UNITY), 17'(UNITY)));
    send_item(make_item(pa, pb, pc, pd, 17'h1FFFF, 17'h1FFFF));
    send_item(make_item('1, '0, '0, '0, 17'd32768, 17'd32768));
    settle();

    // BGR: upper pixel bits ignored, alpha forced full.
    set_format(FMT_BGR8);
    send_item(make_item('1, '1, '1, '1, 17'd0, 17'd0));
    send_item(make_item(64'hFFFF_FFFF_FF00_0000, '0, '0, '0, 17'd40000, 17'd0));
    send_item(make_item(pa, pb, pc, pd, 17'h1FFFF, 17'd0));
    send_item(make_item(pa, pb, pc, pd, 17'd0, 17'h1FFFF));
    settle();

    // RGBA 16-bit extremes.
    set_format(FMT_RGBA16);
    send_item(make_item('1, '1, '1, '1, 17'd12345, 17'd54321));
    send_item(make_item('0, '0, '0, '0, 17'd65535, 17'd65535));
    send_item(make_item('1, '0, '0, '1, 17'd32768, 17'd32768));
    send_item(make_item(pa, pb, pc, pd, 17'd1, 17'd65535));
    send_item(make_item(pa, pb, pc, pd, 17'h10001, 17'd1));
    settle();

    // A write to the empty register index must leave 16-bit mode in place.
    write_reg(REG_UNUSED, 32'd0);
    check_format_reg();
    send_item(make_item(pa, pb, pc, pd, 17'd20000, 17'd30000));
    send_item(make_item(pd, pc, pb, pa, 17'd50000, 17'd10000));
    settle();

    // Format code three behaves as 16-bit RGBA.
    set_format(FMT_ALIAS16);
    send_item(make_item(pa, pb, pc, pd, 17'd32768, 17'd16384));
    send_item(make_item('1, '0, '1, '0, 17'd65535, 17'd1));
    settle();

    // Random phases, one pixel format each.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
      set_format(phase_fmt[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Long receiver hold-off while the sender keeps offering items.
        if (p == 2 && i == 40) begin
          quiet    = 1'b1;
          hold_req = 1'b1;
        end
        send_item(rand_item());
      end
      quiet = 1'b0;
      settle();
    end

    if (sb.errors == 0) begin
      $display("bilinear_pixel_interpolator_unit verification clean");
    end else begin
      $display("bilinear_pixel_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bpi_pkg.sv
rtl/bpi_lane.sv
rtl/bpi_merge.sv
rtl/bilinear_pixel_interpolator_unit.sv
bench/bilinear_pixel_interpolator_unit_tb.sv
